// File: hw/rtl/text_statistics_counter_macros.svh
// Assertion macros used by the text statistics counter checker.
`ifndef TEXT_STATISTICS_COUNTER_MACROS_SVH
`define TEXT_STATISTICS_COUNTER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define TSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked during reset too.
`define TSC_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tsc_pkg.sv
// Types, constants and byte classes of the text statistics counter.
package tsc_pkg;

   localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
   localparam logic [7:0] UNDERSCORE_BYTE = 8'h5F;
   localparam logic [7:0] HYPHEN_BYTE     = 8'h2D;
   localparam logic [7:0] SPACE_BYTE      = 8'h20;
   localparam logic [7:0] TAB_BYTE        = 8'h09;
   localparam logic [7:0] CR_BYTE         = 8'h0D;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] ch;
      logic       start_of_text;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [31:0] char_count;
      logic [31:0] nonspace_count;
      logic [31:0] word_count;
      logic [31:0] line_count;
      logic [31:0] blank_line_count;
      logic [15:0] longest_line;
   } rsp_type;

   // Classified byte as it travels from the front end to the counters.
   typedef struct packed {
      logic start_of_text;
      logic end_of_text;
      logic blank;
      logic word;
      logic newline;
   } cls_item_type;

   function automatic logic is_blank_byte(input logic [7:0] c);
      return (c == SPACE_BYTE) || ((c >= TAB_BYTE) && (c <= CR_BYTE));
   endfunction

   function automatic logic is_word_byte(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) || (c == UNDERSCORE_BYTE) ||
             (c == HYPHEN_BYTE);
   endfunction

endpackage

// File: hw/rtl/tsc_front.sv
// Front end: accepts text bytes, classifies them and pushes them to the queue.
module tsc_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tsc_pkg::req_type      req_payload,
   output logic                  push,
   output tsc_pkg::cls_item_type push_item,
   input  logic                  queue_full
);
   import tsc_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.start_of_text = req_payload.start_of_text;
      push_item.end_of_text   = req_payload.end_of_text;
      push_item.blank         = is_blank_byte(req_payload.ch);
      push_item.word          = is_word_byte(req_payload.ch);
      push_item.newline       = (req_payload.ch == NEWLINE_BYTE);
   end

endmodule

// File: hw/rtl/tsc_queue.sv
// Short queue of classified bytes between the front end and the counters.
module tsc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tsc_pkg::cls_item_type push_item,
   output logic                  full,
   output logic                  pop_valid,
   output tsc_pkg::cls_item_type pop_item,
   input  logic                  pop
);
   import tsc_pkg::*;

   cls_item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/tsc_back.sv
// Back end: running counters, line tracking and the result register.
module tsc_back #(
   parameter int COUNT_WIDTH  = 32,
   parameter int LENGTH_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  tsc_pkg::cls_item_type pop_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tsc_pkg::rsp_type      rsp_payload
);
   import tsc_pkg::*;

   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic [COUNT_WIDTH-1:0]  visible_ff, visible_in;
   logic [COUNT_WIDTH-1:0]  words_ff, words_in;
   logic [COUNT_WIDTH-1:0]  lines_ff, lines_in;
   logic [COUNT_WIDTH-1:0]  blank_ff, blank_in;
   logic [LENGTH_WIDTH-1:0] max_len_ff, max_len_in;
   logic [LENGTH_WIDTH-1:0] cur_len_ff, cur_len_in;
   logic                    in_word_ff, in_word_in;
   logic                    has_vis_ff, has_vis_in;
   logic                    valid_ff, valid_in;

   logic [COUNT_WIDTH-1:0]  total_base, visible_base, words_base, lines_base, blank_base;
   logic [LENGTH_WIDTH-1:0] max_base, cur_base, close_len;
   logic                    in_word_base, has_vis_base, has_vis_new, closing;

   // Take the next item when the result register is empty or being drained.
   assign pop       = pop_valid && (!valid_ff || !rsp_stall);
   assign rsp_valid = valid_ff;

   always_comb begin
      valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);

      // Start of text clears everything before the byte is counted.
      total_base   = pop_item.start_of_text ? '0 : total_ff;
      visible_base = pop_item.start_of_text ? '0 : visible_ff;
      words_base   = pop_item.start_of_text ? '0 : words_ff;
      lines_base   = pop_item.start_of_text ? '0 : lines_ff;
      blank_base   = pop_item.start_of_text ? '0 : blank_ff;
      max_base     = pop_item.start_of_text ? '0 : max_len_ff;
      cur_base     = pop_item.start_of_text ? '0 : cur_len_ff;
      in_word_base = pop_item.start_of_text ? 1'b0 : in_word_ff;
      has_vis_base = pop_item.start_of_text ? 1'b0 : has_vis_ff;

      total_in   = (&total_base) ? total_base : total_base + 1'b1;
      visible_in = visible_base;
      if (!pop_item.blank && !(&visible_base)) begin
         visible_in = visible_base + 1'b1;
      end
      has_vis_new = has_vis_base || !pop_item.blank;

      words_in = words_base;
      if (pop_item.word && !in_word_base && !(&words_base)) begin
         words_in = words_base + 1'b1;
      end

      // A newline is not part of the line length; any other byte is.
      close_len = cur_base;
      if (!pop_item.newline && !(&cur_base)) begin
         close_len = cur_base + 1'b1;
      end
      closing = pop_item.newline || pop_item.end_of_text;

      lines_in   = lines_base;
      blank_in   = blank_base;
      max_len_in = max_base;
      if (closing) begin
         if (!(&lines_base)) begin
            lines_in = lines_base + 1'b1;
         end
         if (!has_vis_new && !(&blank_base)) begin
            blank_in = blank_base + 1'b1;
         end
         if (close_len > max_base) begin
            max_len_in = close_len;
         end
         cur_len_in = '0;
         has_vis_in = 1'b0;
         in_word_in = 1'b0;
      end else begin
         cur_len_in = close_len;
         has_vis_in = has_vis_new;
         in_word_in = pop_item.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         total_ff   <= '0;
         visible_ff <= '0;
         words_ff   <= '0;
         lines_ff   <= '0;
         blank_ff   <= '0;
         max_len_ff <= '0;
         cur_len_ff <= '0;
         in_word_ff <= 1'b0;
         has_vis_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            total_ff   <= total_in;
            visible_ff <= visible_in;
            words_ff   <= words_in;
            lines_ff   <= lines_in;
            blank_ff   <= blank_in;
            max_len_ff <= max_len_in;
            cur_len_ff <= cur_len_in;
            in_word_ff <= in_word_in;
            has_vis_ff <= has_vis_in;
         end
      end
   end

   // Counters change only on a pop, so they hold while the result is stalled.
   always_comb begin
      rsp_payload.char_count       = 32'(total_ff);
      rsp_payload.nonspace_count   = 32'(visible_ff);
      rsp_payload.word_count       = 32'(words_ff);
      rsp_payload.line_count       = 32'(lines_ff);
      rsp_payload.blank_line_count = 32'(blank_ff);
      rsp_payload.longest_line     = 16'(max_len_ff);
   end

endmodule

// File: hw/rtl/text_statistics_counter.sv
// Text statistics counter: per-byte word, line and character counts.
//
// Input channel req_*: one text byte per item with start_of_text (clear all
// counts before this byte) and end_of_text (close an unterminated last line).
// Result channel rsp_*: exactly one result per input item, in order, holding
// the counts after that byte: bytes, non-whitespace bytes, words, lines,
// whitespace-only lines and the longest closed line. All counters saturate.
// Each accepted item is written into the four-entry classification queue,
// then taken by the counter stage, which updates the counters and registers
// the result; a stalled result can hold items in the queue.
// Throughput: one item per cycle while the result channel is not stalled.
// The front end stalls only when the queue is full; a stalled result holds
// the counter stage, and the queue keeps taking items until it fills.
// Reset (synchronous, active high) clears all counts, empties the queue and
// drops any pending result; the block can take items again once reset is low.
module text_statistics_counter #(
   parameter int COUNT_WIDTH  = 32,
   parameter int LENGTH_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsc_pkg::rsp_type rsp_payload
);
   import tsc_pkg::*;

   cls_item_type push_item, pop_item;
   logic         push, queue_full, pop_valid, pop;

   tsc_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push        (push),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   tsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop)
   );

   tsc_back #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hw/rtl/tsc_checker.sv
// Port-level checker for the text statistics counter and its bind.
`include "text_statistics_counter_macros.svh"

module tsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tsc_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tsc_pkg::rsp_type rsp_payload
);
   import tsc_pkg::*;

   logic unused_in;
   logic rsp_waiting;
   logic blank_ok;
   logic visible_ok;

   assign unused_in   = req_valid ^ req_stall ^ (^req_payload);
   assign rsp_waiting = !reset && rsp_valid && rsp_stall;
   assign blank_ok    = rsp_payload.blank_line_count <= rsp_payload.line_count;
   assign visible_ok  = rsp_payload.nonspace_count <= rsp_payload.char_count;

   `TSC_ASSERT_NEXT(a_rsp_held, clock, rsp_waiting, rsp_valid, "result dropped while stalled")
   `TSC_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")
   `TSC_ASSERT_IMPL(a_blank_le_lines, clock, reset, rsp_valid, blank_ok, "blank over lines")
   `TSC_ASSERT_IMPL(a_visible_le_chars, clock, reset, rsp_valid, visible_ok, "visible over bytes")

endmodule

bind text_statistics_counter tsc_checker u_tsc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// File: verif/text_statistics_counter_tb.sv
// Self-checking testbench for the text statistics counter.
module text_statistics_counter_tb;
   import tsc_pkg::*;

   localparam int RANDOM_ITEMS   = 1120;
   localparam int LONG_LINE_LEN  = 300;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 4;
   localparam logic [7:0] VT_BYTE = 8'h0B;
   localparam logic [7:0] FF_BYTE = 8'h0C;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // Predicted counter state.
   logic [31:0] tally_bytes    = '0;
   logic [31:0] tally_visible  = '0;
   logic [31:0] tally_words    = '0;
   logic [31:0] tally_lines    = '0;
   logic [31:0] tally_blank    = '0;
   logic [15:0] tally_longest  = '0;
   logic [15:0] tally_line_len = '0;
   logic        in_word        = 1'b0;
   logic        line_visible   = 1'b0;

   rsp_type expected_counts[$];
   int      errors      = 0;
   int      bytes_sent  = 0;
   int      idle_cycles = 0;
   logic    quiet       = 1'b0;

   text_statistics_counter uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] bump_count(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic logic [15:0] bump_length(input logic [15:0] v);
      return (v == '1) ? v : v + 16'd1;
   endfunction

   task automatic close_current_line();
      tally_lines = bump_count(tally_lines);
      if (!line_visible) tally_blank = bump_count(tally_blank);
      if (tally_line_len > tally_longest) tally_longest = tally_line_len;
      tally_line_len = '0;
      line_visible   = 1'b0;
      in_word        = 1'b0;
   endtask

   // Advance the predicted counts by one byte and return the counts after it.
   task automatic advance_counts(input req_type item, output rsp_type counts);
      logic is_space;
      logic is_word;
      is_space = (item.ch == SPACE_BYTE) || (item.ch inside {[TAB_BYTE:CR_BYTE]});
      is_word  = (item.ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
                 (item.ch == UNDERSCORE_BYTE) || (item.ch == HYPHEN_BYTE);
      if (item.start_of_text) begin
         tally_bytes    = '0;
         tally_visible  = '0;
         tally_words    = '0;
         tally_lines    = '0;
         tally_blank    = '0;
         tally_longest  = '0;
         tally_line_len = '0;
         in_word        = 1'b0;
         line_visible   = 1'b0;
      end
      tally_bytes = bump_count(tally_bytes);
      if (!is_space) begin
         tally_visible = bump_count(tally_visible);
         line_visible  = 1'b1;
      end
      if (is_word) begin
         if (!in_word) tally_words = bump_count(tally_words);
         in_word = 1'b1;
      end else begin
         in_word = 1'b0;
      end
      if (item.ch == NEWLINE_BYTE) begin
         close_current_line();
      end else begin
         tally_line_len = bump_length(tally_line_len);
         if (item.end_of_text) close_current_line();
      end
      counts.char_count       = tally_bytes;
      counts.nonspace_count   = tally_visible;
      counts.word_count       = tally_words;
      counts.line_count       = tally_lines;
      counts.blank_line_count = tally_blank;
      counts.longest_line     = tally_longest;
   endtask

   task automatic compare_counts(input rsp_type want, input rsp_type got);
      string       field[6];
      logic [31:0] want_f[6];
      logic [31:0] got_f[6];
      field  = '{"char_count", "nonspace_count", "word_count", "line_count",
                 "blank_line_count", "longest_line"};
      want_f = '{want.char_count, want.nonspace_count, want.word_count, want.line_count,
                 want.blank_line_count, {16'h0, want.longest_line}};
      got_f  = '{got.char_count, got.nonspace_count, got.word_count, got.line_count,
                 got.blank_line_count, {16'h0, got.longest_line}};
      for (int i = 0; i < 6; i++) begin
         if (got_f[i] !== want_f[i]) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field[i], want_f[i], got_f[i]);
            errors++;
         end
      end
   endtask

   // Present one item, hold it until taken, then record its expected counts.
   task automatic send_item(input logic [7:0] ch, input logic sot, input logic eot);
      int      gap;
      req_type item;
      rsp_type counts;
      gap = 0;
      if (!quiet && $urandom_range(99) < 6) gap = $urandom_range(1, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.ch            = ch;
      item.start_of_text = sot;
      item.end_of_text   = eot;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      advance_counts(item, counts);
      expected_counts.push_back(counts);
      bytes_sent++;
   endtask

   function automatic logic [7:0] pick_text_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         unique case ($urandom_range(3))
            0: return 8'h61 + 8'($urandom_range(25));
            1: return 8'h41 + 8'($urandom_range(25));
            2: return 8'h30 + 8'($urandom_range(9));
            default: return $urandom_range(1) ? UNDERSCORE_BYTE : HYPHEN_BYTE;
         endcase
      end else if (pick < 70) begin
         return $urandom_range(1) ? SPACE_BYTE : TAB_BYTE;
      end else if (pick < 78) begin
         return NEWLINE_BYTE;
      end else if (pick < 85) begin
         unique case ($urandom_range(2))
            0: return VT_BYTE;
            1: return FF_BYTE;
            default: return CR_BYTE;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   // Word class boundaries and every whitespace byte, then line closing at end of text.
   task automatic test_byte_classes();
      send_item(8'h61, 1'b1, 1'b0);
      send_item(HYPHEN_BYTE, 1'b0, 1'b0);
      send_item(UNDERSCORE_BYTE, 1'b0, 1'b0);
      send_item(8'h2F, 1'b0, 1'b0);
      send_item(8'h30, 1'b0, 1'b0);
      send_item(TAB_BYTE, 1'b0, 1'b0);
      send_item(8'h39, 1'b0, 1'b0);
      send_item(8'h3A, 1'b0, 1'b0);
      send_item(8'h41, 1'b0, 1'b0);
      send_item(VT_BYTE, 1'b0, 1'b0);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h5B, 1'b0, 1'b0);
      send_item(8'h7A, 1'b0, 1'b0);
      send_item(FF_BYTE, 1'b0, 1'b0);
      send_item(8'h40, 1'b0, 1'b0);
      send_item(8'h60, 1'b0, 1'b0);
      send_item(8'h7B, 1'b0, 1'b0);
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0, 1'b0);
      send_item(SPACE_BYTE, 1'b0, 1'b0);
      send_item(CR_BYTE, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0, 1'b1);
   endtask

   // Texts of one byte: start and end flags on the same item.
   task automatic test_single_byte_texts();
      send_item(8'h71, 1'b1, 1'b1);
      send_item(NEWLINE_BYTE, 1'b1, 1'b1);
      send_item(SPACE_BYTE, 1'b1, 1'b1);
   endtask

   // One long line sent back to back: lengths past eight bits, then a short line.
   task automatic test_long_line();
      logic [7:0] b;
      quiet = 1'b1;
      for (int i = 0; i < LONG_LINE_LEN; i++) begin
         do b = 8'($urandom_range(255)); while (b == NEWLINE_BYTE);
         send_item(b, i == 0, i == LONG_LINE_LEN - 1);
      end
      send_item(8'h61, 1'b0, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0, 1'b0);
      quiet = 1'b0;
   endtask

   // Mostly well-formed texts with random content, some stray flagged bytes.
   task automatic test_random_text();
      int stop_at;
      int len;
      stop_at = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(9) == 0) begin
            send_item(8'($urandom_range(255)), $urandom_range(99) < 5,
                      $urandom_range(99) < 5);
         end else begin
            len = $urandom_range(1, 60);
            for (int i = 0; i < len; i++)
               send_item(pick_text_byte(), i == 0, i == len - 1);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %p", $time, rsp_payload);
            errors++;
         end else begin
            compare_counts(expected_counts.pop_front(), rsp_payload);
         end
      end
      rsp_stall <= !quiet && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_byte_classes();
      test_single_byte_texts();
      test_long_line();
      test_random_text();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
